// ===== design/rvie_pkg.sv =====
// Shared constants for the register machine instruction executor.
// Holds the opcode and status codes, the storage depths and the derived widths.
// No dependencies.
package rvie_pkg;

  localparam int PROGRAM_DEPTH = 1024;
  localparam int STACK_DEPTH = 1024;
  localparam int REG_COUNT = 256;

  localparam int RA_W = $clog2(REG_COUNT);
  localparam int SA_W = $clog2(STACK_DEPTH);
  localparam int SP_W = $clog2(STACK_DEPTH + 1);

  localparam logic [3:0] OP_MOV = 4'd1;
  localparam logic [3:0] OP_ADD = 4'd2;
  localparam logic [3:0] OP_SUB = 4'd3;
  localparam logic [3:0] OP_MUL = 4'd4;
  localparam logic [3:0] OP_DIV = 4'd5;
  localparam logic [3:0] OP_LOAD = 4'd6;
  localparam logic [3:0] OP_PRINT = 4'd7;
  localparam logic [3:0] OP_ASSERT = 4'd8;
  localparam logic [3:0] OP_CALL = 4'd9;
  localparam logic [3:0] OP_RET = 4'd10;
  localparam logic [3:0] OP_EXIT = 4'd11;
  localparam logic [3:0] OP_LABEL = 4'd12;

  localparam logic [2:0] ST_RUN = 3'd0;
  localparam logic [2:0] ST_EXIT = 3'd1;
  localparam logic [2:0] ST_ASSERT = 3'd2;
  localparam logic [2:0] ST_UNDER = 3'd3;
  localparam logic [2:0] ST_BADOP = 3'd4;
  localparam logic [2:0] ST_OVER = 3'd5;
  localparam logic [2:0] ST_DIVZ = 3'd6;
  localparam logic [2:0] ST_END = 3'd7;

endpackage

// ===== design/register_vm_instruction_executor.sv =====
// Register machine instruction executor: register file, call stack and sequencer.
// Depends on rvie_pkg for opcodes, status codes, depths and widths.
// Executes one instruction per input beat and returns one result beat for it.

// Each input beat is the instruction at the last reported next_pc (position zero
// after reset). The block keeps its registers in a synchronous memory with a
// registered read and a valid bit per entry, so registers read as zero until first
// written; the call stack is a second synchronous memory that is never cleared.
// One instruction is worked on at a time. A plain instruction passes, from one
// accepted beat to the next, through accept and read, execute, and the handoff of
// the result to the output register. Multiply adds a state for its product
// register, call adds states for its three stack writes, return adds states for its
// three stack reads through the single stack read port, and divide runs an
// iterative restoring divider. Once the block halts, every later beat is
// answered with the same next_pc and status and no value until reset. The
// result sits in an output register; while the output side stalls with that
// register full, a finished result waits and the next beat is not accepted.
module register_vm_instruction_executor (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         req_type,
  input  logic [7:0]         dest_reg,
  input  logic signed [31:0] operand,
  input  logic [9:0]         call_target,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [10:0]        next_pc,
  output logic [2:0]         status,
  output logic               value_valid,
  output logic signed [31:0] value
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_READ = 4'd1;
  localparam logic [3:0] S_MUL = 4'd2;
  localparam logic [3:0] S_DIV = 4'd3;
  localparam logic [3:0] S_DIVW = 4'd4;
  localparam logic [3:0] S_CALL1 = 4'd5;
  localparam logic [3:0] S_CALL2 = 4'd6;
  localparam logic [3:0] S_RET2 = 4'd7;
  localparam logic [3:0] S_RET3 = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  logic [3:0] state;
  logic [rvie_pkg::SP_W-1:0] sp;
  logic [10:0] pc;
  logic [2:0] halt;

  // Latched instruction.
  logic [3:0] op;
  logic [rvie_pkg::RA_W-1:0] dreg;
  logic [31:0] imm;
  logic [9:0] tgt;

  // Register file memory with per-entry valid bits.
  logic [31:0] rf [0:rvie_pkg::REG_COUNT-1];
  logic [rvie_pkg::REG_COUNT-1:0] rf_vld;
  logic [31:0] rd_a, rd_b;
  logic va, vb;
  logic [rvie_pkg::RA_W-1:0] ra_a, ra_b, rf_wa;
  logic rf_we;
  logic [31:0] rf_wd;

  // Call stack memory.
  logic [31:0] stk [0:rvie_pkg::STACK_DEPTH-1];
  logic [31:0] stk_rd;
  logic [rvie_pkg::SA_W-1:0] stk_ra, stk_wa;
  logic stk_we;
  logic [31:0] stk_wd;

  // Operands and working registers.
  logic [31:0] a, b, opa, opb, prod;
  logic [31:0] dq, dv, rem;
  logic neg;
  logic [4:0] cnt;
  logic [32:0] rem_sh, diff;

  // Result waiting for the output register.
  logic [10:0] res_pc;
  logic [2:0] res_st;
  logic res_vv;
  logic [31:0] res_val;

  // Step outcome decoded combinationally.
  logic fin, hlt, fin_vv;
  logic [31:0] fin_next, fin_val, hlt_val;
  logic hlt_vv;
  logic [2:0] hlt_code;

  logic [rvie_pkg::SP_W-1:0] sp_p1, sp_p2, sp_m1, sp_m2, sp_m3;
  logic [31:0] pc_p1;
  logic accept;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign a = va ? rd_a : 32'd0;
  assign b = vb ? rd_b : 32'd0;
  assign sp_p1 = sp + rvie_pkg::SP_W'(1);
  assign sp_p2 = sp + rvie_pkg::SP_W'(2);
  assign sp_m1 = sp - rvie_pkg::SP_W'(1);
  assign sp_m2 = sp - rvie_pkg::SP_W'(2);
  assign sp_m3 = sp - rvie_pkg::SP_W'(3);
  assign pc_p1 = {21'd0, pc} + 32'd1;
  assign rem_sh = {1'b0, rem[30:0], dq[31]};
  assign diff = rem_sh - {1'b0, dv};

  // Register and stack addresses, write ports and the outcome of each step.
  always_comb begin
    ra_a = dest_reg[rvie_pkg::RA_W-1:0];
    ra_b = operand[rvie_pkg::RA_W-1:0];
    if (req_type == rvie_pkg::OP_CALL) begin
      // A call saves R8 and R7, so it reads those instead.
      ra_a = rvie_pkg::RA_W'(8);
      ra_b = rvie_pkg::RA_W'(7);
    end
    rf_we = 1'b0;
    rf_wa = dreg;
    rf_wd = 32'd0;
    stk_we = 1'b0;
    stk_wa = sp[rvie_pkg::SA_W-1:0];
    stk_wd = 32'd0;
    stk_ra = sp_m1[rvie_pkg::SA_W-1:0];
    fin = 1'b0;
    fin_next = pc_p1;
    fin_vv = 1'b0;
    fin_val = 32'd0;
    hlt = 1'b0;
    hlt_code = rvie_pkg::ST_RUN;
    hlt_vv = 1'b0;
    hlt_val = 32'd0;
    case (state)
      S_READ: begin
        case (op)
          rvie_pkg::OP_MOV: begin
            rf_we = 1'b1;
            rf_wd = b;
            fin = 1'b1;
          end
          rvie_pkg::OP_ADD: begin
            rf_we = 1'b1;
            rf_wd = a + b;
            fin = 1'b1;
          end
          rvie_pkg::OP_SUB: begin
            rf_we = 1'b1;
            rf_wd = a - b;
            fin = 1'b1;
          end
          rvie_pkg::OP_LOAD: begin
            rf_we = 1'b1;
            rf_wd = imm;
            fin = 1'b1;
          end
          rvie_pkg::OP_LABEL: fin = 1'b1;
          rvie_pkg::OP_MUL: ;
          rvie_pkg::OP_DIV: begin
            if (b == 32'd0) begin
              hlt = 1'b1;
              hlt_code = rvie_pkg::ST_DIVZ;
            end
          end
          rvie_pkg::OP_PRINT: begin
            fin = 1'b1;
            fin_vv = 1'b1;
            fin_val = a;
          end
          rvie_pkg::OP_ASSERT: begin
            if (a != imm) begin
              hlt = 1'b1;
              hlt_code = rvie_pkg::ST_ASSERT;
            end else begin
              fin = 1'b1;
            end
          end
          rvie_pkg::OP_CALL: begin
            if (sp > rvie_pkg::SP_W'(rvie_pkg::STACK_DEPTH - 3)) begin
              hlt = 1'b1;
              hlt_code = rvie_pkg::ST_OVER;
            end else begin
              stk_we = 1'b1;
              stk_wd = pc_p1;
            end
          end
          rvie_pkg::OP_RET: begin
            if (sp < rvie_pkg::SP_W'(3)) begin
              hlt = 1'b1;
              hlt_code = rvie_pkg::ST_UNDER;
            end else begin
              rf_we = 1'b1;
              rf_wa = rvie_pkg::RA_W'(1);
              rf_wd = stk_rd;
              stk_ra = sp_m2[rvie_pkg::SA_W-1:0];
            end
          end
          rvie_pkg::OP_EXIT: begin
            hlt = 1'b1;
            hlt_code = rvie_pkg::ST_EXIT;
            hlt_vv = 1'b1;
            hlt_val = a;
          end
          default: begin
            hlt = 1'b1;
            hlt_code = rvie_pkg::ST_BADOP;
          end
        endcase
      end
      S_MUL: begin
        rf_we = 1'b1;
        rf_wd = prod;
        fin = 1'b1;
      end
      S_DIVW: begin
        rf_we = 1'b1;
        rf_wd = neg ? (32'd0 - dq) : dq;
        fin = 1'b1;
      end
      S_CALL1: begin
        stk_we = 1'b1;
        stk_wa = sp_p1[rvie_pkg::SA_W-1:0];
        stk_wd = opa;
      end
      S_CALL2: begin
        stk_we = 1'b1;
        stk_wa = sp_p2[rvie_pkg::SA_W-1:0];
        stk_wd = opb;
        fin = 1'b1;
        fin_next = {22'd0, tgt};
      end
      S_RET2: begin
        rf_we = 1'b1;
        rf_wa = rvie_pkg::RA_W'(2);
        rf_wd = stk_rd;
        stk_ra = sp_m3[rvie_pkg::SA_W-1:0];
      end
      S_RET3: begin
        fin = 1'b1;
        fin_next = stk_rd;
      end
      default: ;
    endcase
  end

  // Register file: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf[rf_wa] <= rf_wd;
    end
    rd_a <= rf[ra_a];
    rd_b <= rf[ra_b];
    va <= rf_vld[ra_a];
    vb <= rf_vld[ra_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_vld <= '0;
    end else if (rf_we) begin
      rf_vld[rf_wa] <= 1'b1;
    end
  end

  // Call stack: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk[stk_wa] <= stk_wd;
    end
    stk_rd <= stk[stk_ra];
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sp <= '0;
      pc <= '0;
      halt <= rvie_pkg::ST_RUN;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            op <= req_type;
            dreg <= dest_reg[rvie_pkg::RA_W-1:0];
            imm <= operand;
            tgt <= call_target;
            if (halt != rvie_pkg::ST_RUN) begin
              res_pc <= pc;
              res_st <= halt;
              res_vv <= 1'b0;
              res_val <= 32'd0;
              state <= S_DONE;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          opa <= a;
          opb <= b;
          if (op == rvie_pkg::OP_MUL) begin
            prod <= a * b;
            state <= S_MUL;
          end else if (op == rvie_pkg::OP_DIV && !hlt) begin
            // Divide magnitudes, then fix the sign when writing back.
            dq <= a[31] ? (32'd0 - a) : a;
            dv <= b[31] ? (32'd0 - b) : b;
            rem <= 32'd0;
            neg <= a[31] ^ b[31];
            cnt <= 5'd31;
            state <= S_DIV;
          end else if (op == rvie_pkg::OP_CALL && !hlt) begin
            state <= S_CALL1;
          end else if (op == rvie_pkg::OP_RET && !hlt) begin
            state <= S_RET2;
          end
        end
        S_DIV: begin
          if (!diff[32]) begin
            rem <= diff[31:0];
            dq <= {dq[30:0], 1'b1};
          end else begin
            rem <= rem_sh[31:0];
            dq <= {dq[30:0], 1'b0};
          end
          if (cnt == 5'd0) begin
            state <= S_DIVW;
          end
          cnt <= cnt - 5'd1;
        end
        S_CALL1: state <= S_CALL2;
        S_CALL2: sp <= sp_p2 + rvie_pkg::SP_W'(1);
        S_RET2: state <= S_RET3;
        S_RET3: sp <= sp_m3;
        default: ;
      endcase

      if (fin) begin
        pc <= fin_next[10:0];
        res_pc <= fin_next[10:0];
        res_vv <= fin_vv;
        res_val <= fin_val;
        if (fin_next >= 32'(rvie_pkg::PROGRAM_DEPTH)) begin
          halt <= rvie_pkg::ST_END;
          res_st <= rvie_pkg::ST_END;
        end else begin
          res_st <= rvie_pkg::ST_RUN;
        end
        state <= S_DONE;
      end
      if (hlt) begin
        halt <= hlt_code;
        res_pc <= pc;
        res_st <= hlt_code;
        res_vv <= hlt_vv;
        res_val <= hlt_val;
        state <= S_DONE;
      end

      // Output register: a finished result fills it, a taken beat frees it.
      if (state == S_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
        next_pc <= res_pc;
        status <= res_st;
        value_valid <= res_vv;
        value <= res_val;
        state <= S_IDLE;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
